// File: hw/rtl/hts_pkg.sv
// shared constants, codes and types of the thermostat block
package hts_pkg;

    // history and tick
    localparam int HIST_DEPTH   = 5;
    localparam int TICK_SECONDS = 2;

    // field widths
    localparam int OP_W       = 2;
    localparam int RAW_W      = 14;
    localparam int TEMP_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int MSG_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

    // report codes
    localparam logic [MSG_W-1:0] MSG_NONE  = 2'd0;
    localparam logic [MSG_W-1:0] MSG_START = 2'd1;
    localparam logic [MSG_W-1:0] MSG_STOP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OPT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX = 2'd3;

    // register reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd60;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RESET = 8'sd15;
    localparam logic signed [TEMP_W-1:0] TEMP_OPT_RESET = 8'sd19;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RESET = 8'sd23;

    localparam logic [INTERVAL_W-1:0] TICK_STEP = INTERVAL_W'(TICK_SECONDS);

    // sensor conversion: ((raw / 10) - 396) / 10
    localparam int TEMP_OFFSET  = 396;
    localparam int DIV10_SHIFT  = 19;
    localparam int DIV10_MUL    = (2**DIV10_SHIFT + 9) / 10;
    localparam int DIV10_MUL_W  = 16;
    localparam int Q_W          = 11;
    localparam int DIFF_W       = Q_W + 1;
    localparam int Q_PROD_W     = RAW_W + DIV10_MUL_W;
    localparam int MAG_PROD_W   = Q_W + DIV10_MUL_W;

    // history average: sum / HIST_DEPTH by reciprocal
    localparam int SUM_W      = TEMP_W + $clog2(HIST_DEPTH);
    localparam int AVG_SHIFT  = 16;
    localparam int AVG_MUL    = (2**AVG_SHIFT + HIST_DEPTH - 1) / HIST_DEPTH;
    localparam int AVG_MUL_W  = 16;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

    // converted word heading for the control stage
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [TEMP_W-1:0] temp;
    } hts_item_t;

    // result word
    typedef struct packed {
        logic                     comfort;
        logic                     blue;
        logic                     cooling;
        logic [MSG_W-1:0]         msg;
        logic                     sampled;
        logic signed [TEMP_W-1:0] temp;
        logic signed [TEMP_W-1:0] avg;
    } hts_result_t;

endpackage

// File: hw/rtl/hts_conv.sv
// input register and two-stage raw sensor word to degrees conversion
module hts_conv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hts_pkg::OP_W-1:0]   op,
    input  logic [hts_pkg::RAW_W-1:0]  raw_temp,
    output logic                       item_valid,
    input  logic                       item_ready,
    output hts_pkg::hts_item_t         item
);
    import hts_pkg::*;

    logic                   s0_valid_reg;
    logic [OP_W-1:0]        s0_op_reg;
    logic [RAW_W-1:0]       s0_raw_reg;
    logic                   s1_valid_reg;
    logic [OP_W-1:0]        s1_op_reg;
    logic [Q_W-1:0]         s1_q_reg;
    logic                   s2_valid_reg;
    hts_item_t              s2_item_reg;

    logic                   s0_ready;
    logic                   s1_ready;
    logic                   s2_ready;

    logic [Q_PROD_W-1:0]    q_prod;
    logic signed [DIFF_W-1:0] diff;
    logic [Q_W-1:0]         mag;
    logic [MAG_PROD_W-1:0]  mag_prod;
    logic [TEMP_W-2:0]      tq;
    logic signed [TEMP_W-1:0] temp_conv;

    // each stage moves when the one after it is empty or moving
    assign s2_ready = !s2_valid_reg || item_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    // raw / 10
    assign q_prod = Q_PROD_W'(s0_raw_reg) * Q_PROD_W'(DIV10_MUL);

    // (q - offset) / 10, truncated toward zero
    always_comb
    begin
        diff     = $signed({1'b0, s1_q_reg}) - DIFF_W'(TEMP_OFFSET);
        mag      = diff[DIFF_W-1] ? Q_W'(-diff) : Q_W'(diff);
        mag_prod = MAG_PROD_W'(mag) * MAG_PROD_W'(DIV10_MUL);
        tq       = mag_prod[DIV10_SHIFT +: TEMP_W-1];
        temp_conv = diff[DIFF_W-1] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready)
        begin
            s0_op_reg  <= op;
            s0_raw_reg <= raw_temp;
        end
        if (s1_ready)
        begin
            s1_op_reg <= s0_op_reg;
            s1_q_reg  <= q_prod[DIV10_SHIFT +: Q_W];
        end
        if (s2_ready)
        begin
            s2_item_reg.op   <= s1_op_reg;
            s2_item_reg.temp <= temp_conv;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

// File: hw/rtl/hts_core.sv
// thermostat state, sample history, hysteresis decision and result register
module hts_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  hts_pkg::hts_item_t                item,
    input  logic [hts_pkg::INTERVAL_W-1:0]    interval,
    input  logic signed [hts_pkg::TEMP_W-1:0] temp_min,
    input  logic signed [hts_pkg::TEMP_W-1:0] temp_opt,
    input  logic signed [hts_pkg::TEMP_W-1:0] temp_max,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hts_pkg::hts_result_t              result
);
    import hts_pkg::*;

    logic                     comfort_reg;
    logic                     cooling_reg;
    logic                     blue_reg;
    logic [INTERVAL_W-1:0]    cd_reg;
    logic                     hist_valid_reg;
    logic signed [TEMP_W-1:0] hist_reg [HIST_DEPTH];
    logic                     out_valid_reg;
    hts_result_t              res_reg;

    logic                     comfort_next;
    logic                     cooling_next;
    logic                     blue_next;
    logic [INTERVAL_W-1:0]    cd_next;
    logic                     hist_valid_next;
    logic                     hist_load;
    logic                     hist_fill;
    hts_result_t              res_next;

    logic                     item_fire;
    logic                     due;
    logic [INTERVAL_W-1:0]    cd_loaded;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         sum_mag;
    logic [AVG_PROD_W-1:0]    avg_prod;
    logic [TEMP_W-1:0]        avg_q;
    logic signed [TEMP_W-1:0] avg_div;
    logic signed [TEMP_W-1:0] avg;

    assign item_ready = !out_valid_reg || out_ready;
    assign item_fire  = item_valid && item_ready;

    // mean of the stored history, truncated toward zero
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            sum = sum + SUM_W'(hist_reg[i]);
        end
        sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        avg_prod = AVG_PROD_W'(sum_mag) * AVG_PROD_W'(AVG_MUL);
        avg_q    = avg_prod[AVG_SHIFT +: TEMP_W];
        avg_div  = sum[SUM_W-1] ? -$signed(avg_q) : $signed(avg_q);
    end

    always_comb
    begin
        comfort_next    = comfort_reg;
        cooling_next    = cooling_reg;
        blue_next       = blue_reg;
        cd_next         = cd_reg;
        hist_valid_next = hist_valid_reg;
        hist_load       = 1'b0;
        hist_fill       = 1'b0;
        due             = cd_reg <= TICK_STEP;
        cd_loaded       = due ? interval : cd_reg;
        avg             = hist_valid_reg ? avg_div : item.temp;
        res_next.msg     = MSG_NONE;
        res_next.sampled = 1'b0;
        res_next.temp    = '0;
        res_next.avg     = '0;

        case (item.op)
            OP_BUTTON:
            begin
                if (!comfort_reg)
                begin
                    comfort_next = 1'b1;
                    cd_next      = '0;
                    res_next.msg = MSG_START;
                end
                else
                begin
                    comfort_next = 1'b0;
                    blue_next    = 1'b0;
                    res_next.msg = MSG_STOP;
                end
            end
            OP_START:
            begin
                if (!comfort_reg)
                begin
                    comfort_next = 1'b1;
                    cd_next      = '0;
                end
            end
            OP_STOP:
            begin
                comfort_next = 1'b0;
                blue_next    = 1'b0;
            end
            default:
            begin
                if (comfort_reg)
                begin
                    if (due)
                    begin
                        res_next.sampled = 1'b1;
                        res_next.temp    = item.temp;
                        res_next.avg     = avg;
                        hist_load        = 1'b1;
                        hist_fill        = !hist_valid_reg;
                        hist_valid_next  = 1'b1;
                        if (item.temp <= temp_min || avg < temp_opt)
                        begin
                            cooling_next = 1'b1;
                        end
                        else if (item.temp >= temp_max || avg > temp_opt)
                        begin
                            cooling_next = 1'b0;
                        end
                    end
                    blue_next = cooling_next ? !blue_reg : 1'b0;
                    cd_next   = (cd_loaded > TICK_STEP) ? cd_loaded - TICK_STEP : '0;
                end
            end
        endcase

        res_next.comfort = comfort_next;
        res_next.blue    = blue_next;
        res_next.cooling = cooling_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comfort_reg    <= 1'b0;
            cooling_reg    <= 1'b0;
            blue_reg       <= 1'b0;
            cd_reg         <= '0;
            hist_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                comfort_reg    <= comfort_next;
                cooling_reg    <= cooling_next;
                blue_reg       <= blue_next;
                cd_reg         <= cd_next;
                hist_valid_reg <= hist_valid_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // history shift line, filled with the first sample
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            res_reg <= res_next;
            if (hist_load)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    if (hist_fill || i == HIST_DEPTH - 1)
                    begin
                        hist_reg[i] <= item.temp;
                    end
                    else
                    begin
                        hist_reg[i] <= hist_reg[i+1];
                    end
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    a_blue_needs_cooling: assert property (@(posedge clk) disable iff (!rst_n)
        !cooling_reg |-> !blue_reg)
        else $error("blue led lit with cooling off");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.op == OP_TICK && !comfort_reg
        |=> $stable(cooling_reg) && $stable(hist_valid_reg) && !res_reg.sampled)
        else $error("inactive tick changed state");

    a_history_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hist_valid_reg) |-> $past(item_fire) && res_reg.sampled)
        else $error("history marked valid without a sample");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

// File: hw/rtl/hysteresis_thermostat_moving_average.sv
// top level of the thermostat controller with moving-average hysteresis
//
// Thermostat controller. Each input word is a two-second tick, a button press,
// or a remote start or stop, and each gives exactly one result word carrying
// the comfort mode, the three LEDs, the cooling demand, a start or stop report
// (button presses only) and, on a tick that samples, the converted temperature
// and the history average that drove the decision. Throughput is one word per
// clock while out_ready is high, and each word passes through four registers:
// an input register, a stage for raw/10, a stage for the offset and second /10
// (each stage holds one reciprocal multiply), then the control stage whose
// state, five-entry history sum and divide by five settle into the result
// register. Because each stage has its own valid bit, in_ready drops only when
// all four registers hold words and out_ready is low. Registers are to be
// written through the cfg port only while the block is idle; the block does not
// enforce it. cfg_ready is always high. No clearing pass is needed after reset.
module hysteresis_thermostat_moving_average (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hts_pkg::OP_W-1:0]          op,
    input  logic [hts_pkg::RAW_W-1:0]         raw_temp,
    // result words
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              comfort_on,
    output logic                              red_led,
    output logic                              green_led,
    output logic                              blue_led,
    output logic                              cooling_on,
    output logic [hts_pkg::MSG_W-1:0]         report_msg,
    output logic                              sample_taken,
    output logic signed [hts_pkg::TEMP_W-1:0] temperature,
    output logic signed [hts_pkg::TEMP_W-1:0] average_temp,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hts_pkg::*;

    // configuration registers
    logic [INTERVAL_W-1:0]    interval_reg;
    logic signed [TEMP_W-1:0] temp_min_reg;
    logic signed [TEMP_W-1:0] temp_opt_reg;
    logic signed [TEMP_W-1:0] temp_max_reg;

    // converted word between the conversion pipe and the control stage
    logic                     item_valid;
    logic                     item_ready;
    hts_item_t                item;
    hts_result_t              result;

    // writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            temp_min_reg <= TEMP_MIN_RESET;
            temp_opt_reg <= TEMP_OPT_RESET;
            temp_max_reg <= TEMP_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_TEMP_MIN: temp_min_reg <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_TEMP_OPT: temp_opt_reg <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_TEMP_MAX: temp_max_reg <= $signed(cfg_data[TEMP_W-1:0]);
                default:      interval_reg <= interval_reg;
            endcase
        end
    end

    // raw sensor word to degrees, state independent so it runs ahead
    hts_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .raw_temp   (raw_temp),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // countdown, history, hysteresis and the result register
    hts_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .interval   (interval_reg),
        .temp_min   (temp_min_reg),
        .temp_opt   (temp_opt_reg),
        .temp_max   (temp_max_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // red shows inactive, green shows active
    assign comfort_on   = result.comfort;
    assign red_led      = !result.comfort;
    assign green_led    = result.comfort;
    assign blue_led     = result.blue;
    assign cooling_on   = result.cooling;
    assign report_msg   = result.msg;
    assign sample_taken = result.sampled;
    assign temperature  = result.temp;
    assign average_temp = result.avg;

endmodule

// File: tb/hysteresis_thermostat_moving_average_tb.sv
// self-checking testbench of the thermostat controller with moving-average hysteresis
module hysteresis_thermostat_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hts_pkg::*;

    // one pending input word: operation and raw sensor reading
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [RAW_W-1:0] raw;
    } thermo_word_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel, all driven to known values from time zero
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op       = OP_TICK;
    logic [RAW_W-1:0]    raw_temp = '0;

    // result channel
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     comfort_on;
    logic                     red_led;
    logic                     green_led;
    logic                     blue_led;
    logic                     cooling_on;
    logic [MSG_W-1:0]         report_msg;
    logic                     sample_taken;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [TEMP_W-1:0] average_temp;

    // register write channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // ready lines sampled at the falling edge before the rising edge that uses them
    logic in_ready_q  = 1'b0;
    logic cfg_ready_q = 1'b0;

    // words waiting for the driver, results waiting for the block
    thermo_word_t pending_words[$];
    hts_result_t  expected_results[$];
    thermo_word_t next_word;
    hts_result_t  exp_r;

    // shadow of the block's registers
    int interval_m = int'(INTERVAL_RESET);
    int tmin_m     = int'(TEMP_MIN_RESET);
    int topt_m     = int'(TEMP_OPT_RESET);
    int tmax_m     = int'(TEMP_MAX_RESET);

    // shadow of the controller state
    logic comfort_m   = 1'b0;
    logic cooling_m   = 1'b0;
    logic blue_m      = 1'b0;
    logic hist_full_m = 1'b0;
    int   countdown_m = 0;
    int   hist_m[HIST_DEPTH];

    // idling controls
    logic quiet     = 1'b0;
    int   send_gap  = 0;
    int   recv_gap  = 0;
    int   hold_left = 0;

    // run statistics
    int mismatch_count = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int samples_seen   = 0;
    int cooling_seen   = 0;
    int reg_writes     = 0;

    hysteresis_thermostat_moving_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .raw_temp     (raw_temp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .comfort_on   (comfort_on),
        .red_led      (red_led),
        .green_led    (green_led),
        .blue_led     (blue_led),
        .cooling_on   (cooling_on),
        .report_msg   (report_msg),
        .sample_taken (sample_taken),
        .temperature  (temperature),
        .average_temp (average_temp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // works out the result word of one accepted input word and queues it
    task automatic predict_thermostat(input logic [OP_W-1:0] op_i, input logic [RAW_W-1:0] raw_i);
        hts_result_t r;
        int          t;
        int          a;
        int          s;
        r = '0;
        t = 0;
        a = 0;
        case (op_i)
            OP_BUTTON:
            begin
                if (!comfort_m)
                begin
                    comfort_m   = 1'b1;
                    countdown_m = 0;
                    r.msg       = MSG_START;
                end
                else
                begin
                    comfort_m = 1'b0;
                    blue_m    = 1'b0;
                    r.msg     = MSG_STOP;
                end
            end
            OP_START:
            begin
                // a start while already active leaves the countdown alone
                if (!comfort_m)
                begin
                    comfort_m   = 1'b1;
                    countdown_m = 0;
                end
            end
            OP_STOP:
            begin
                comfort_m = 1'b0;
                blue_m    = 1'b0;
            end
            default:
            begin
                // ticks only matter while comfort mode is active
                if (comfort_m)
                begin
                    if (countdown_m <= TICK_SECONDS)
                    begin
                        countdown_m = interval_m;
                        r.sampled   = 1'b1;
                        // int division truncates toward zero, also below zero
                        t = ((int'(raw_i) / 10) - TEMP_OFFSET) / 10;
                        if (!hist_full_m)
                        begin
                            // first sample fills the whole history
                            for (int i = 0; i < HIST_DEPTH; i++)
                                hist_m[i] = t;
                            hist_full_m = 1'b1;
                            a = t;
                        end
                        else
                        begin
                            // mean of the history before the new sample goes in
                            s = 0;
                            for (int i = 0; i < HIST_DEPTH; i++)
                                s += hist_m[i];
                            a = s / HIST_DEPTH;
                            for (int i = 0; i < HIST_DEPTH - 1; i++)
                                hist_m[i] = hist_m[i + 1];
                            hist_m[HIST_DEPTH - 1] = t;
                        end
                        if (t <= tmin_m || a < topt_m)
                            cooling_m = 1'b1;
                        else if (t >= tmax_m || a > topt_m)
                            cooling_m = 1'b0;
                    end
                    blue_m = cooling_m ? !blue_m : 1'b0;
                    countdown_m = (countdown_m > TICK_SECONDS) ? countdown_m - TICK_SECONDS : 0;
                end
            end
        endcase
        r.comfort = comfort_m;
        r.blue    = blue_m;
        r.cooling = cooling_m;
        r.temp    = t[TEMP_W-1:0];
        r.avg     = a[TEMP_W-1:0];
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // sender: offers queued words, holds each until accepted, idles in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // the word on the lines is taken at this edge
            if (in_valid && in_ready_q)
            begin
                predict_thermostat(op, raw_temp);
                words_sent++;
            end
            if (!in_valid || in_ready_q)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    op       <= next_word.op;
                    raw_temp <= next_word.raw;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready with random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 9);
            end
        end
    end

    // checker: lines are stable at the falling edge, so a word seen here with
    // valid and ready high is the one taken at the next rising edge
    always @(negedge clk)
    begin
        in_ready_q  <= in_ready;
        cfg_ready_q <= cfg_ready;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected, expected none actual comfort %0d temp %0d",
                         $time, comfort_on, temperature);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r.sampled)
                    samples_seen++;
                if (exp_r.cooling)
                    cooling_seen++;
                check_field("comfort_on", exp_r.comfort, comfort_on);
                check_field("red_led", !exp_r.comfort, red_led);
                check_field("green_led", exp_r.comfort, green_led);
                check_field("blue_led", exp_r.blue, blue_led);
                check_field("cooling_on", exp_r.cooling, cooling_on);
                check_field("report_msg", exp_r.msg, report_msg);
                check_field("sample_taken", exp_r.sampled, sample_taken);
                check_field("temperature", $signed(exp_r.temp), temperature);
                check_field("average_temp", $signed(exp_r.avg), average_temp);
            end
        end
    end

    task automatic push_word(input logic [OP_W-1:0] op_i, input logic [RAW_W-1:0] raw_i);
        thermo_word_t w;
        w.op  = op_i;
        w.raw = raw_i;
        pending_words.push_back(w);
    endtask

    // raw reading that converts to about deg degrees, clamped to the sensor range
    function automatic logic [RAW_W-1:0] raw_near(input int deg);
        int v;
        v = (deg * 10 + TEMP_OFFSET) * 10 + $urandom_range(0, 99);
        if (v < 0)
            v = 0;
        if (v > 2**RAW_W - 1)
            v = 2**RAW_W - 1;
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
            return OP_TICK;
        case ($urandom_range(0, 2))
            0:       return OP_BUTTON;
            1:       return OP_START;
            default: return OP_STOP;
        endcase
    endfunction

    // register write while the block is idle, shadow updated at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready_q)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_INTERVAL: interval_m = int'(data);
            CFG_TEMP_MIN: tmin_m = int'($signed(data[TEMP_W-1:0]));
            CFG_TEMP_OPT: topt_m = int'($signed(data[TEMP_W-1:0]));
            default:      tmax_m = int'($signed(data[TEMP_W-1:0]));
        endcase
    endtask

    task automatic write_thresholds(input int tmin, input int topt, input int tmax);
        write_reg(CFG_TEMP_MIN, tmin);
        write_reg(CFG_TEMP_OPT, topt);
        write_reg(CFG_TEMP_MAX, tmax);
    endtask

    // min below optimal below max, around a random optimal point
    task automatic write_ordered_thresholds(output int topt);
        topt = $urandom_range(0, 149) - 32;
        write_thresholds(topt - $urandom_range(1, 8), topt, topt + $urandom_range(1, 8));
    endtask

    // sender pauses here until every expected result word has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random words: ticks at the given share, readings mostly near center, some full-range noise
    task automatic run_phase(input int n, input int tick_pct, input int center, input int spread);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                push_word(pick_op(tick_pct), RAW_W'($urandom_range(0, 2**RAW_W - 1)));
            else
                push_word(pick_op(tick_pct),
                          raw_near(center + $urandom_range(0, 2 * spread) - spread));
        end
    endtask

    // stimulus sequence
    initial
    begin
        int topt;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: inactive tick and stop, button start, first sample
        // fills the history, start while active, tick not yet due, button stop
        push_word(OP_TICK, '0);
        push_word(OP_STOP, '1);
        push_word(OP_BUTTON, '0);
        push_word(OP_TICK, '1);
        push_word(OP_START, '0);
        push_word(OP_TICK, '0);
        push_word(OP_BUTTON, '1);
        wait_drained();

        // shortest interval: every active tick samples
        write_reg(CFG_INTERVAL, 2);
        push_word(OP_START, '0);
        push_word(OP_TICK, '0);          // coldest reading, cooling on, blue lit
        push_word(OP_TICK, 14'd4355);
        push_word(OP_TICK, 14'd3950);    // negative before second divide, truncates to zero
        push_word(OP_STOP, '0);          // deactivation clears blue, cooling kept
        push_word(OP_BUTTON, '0);
        push_word(OP_TICK, 14'd6500);
        push_word(OP_TICK, 14'd3860);
        push_word(OP_BUTTON, '0);
        wait_drained();

        // reset-like thresholds written explicitly, readings around the band
        write_reg(CFG_INTERVAL, 2);
        write_thresholds(15, 19, 23);
        run_phase(220, 85, 19, 8);
        wait_drained();

        // random ordered band, short interval, long receiver hold-off to back up the pipe
        write_reg(CFG_INTERVAL, $urandom_range(2, 12));
        write_ordered_thresholds(topt);
        run_phase(230, 85, topt, 10);
        @(negedge clk);
        hold_left = 80;
        wait_drained();

        // longest interval and lowest thresholds; many activations so samples occur
        write_reg(CFG_INTERVAL, 65534);
        write_thresholds(-40, -40, -40);
        run_phase(150, 60, 0, 60);
        wait_drained();

        // highest thresholds, odd interval
        write_reg(CFG_INTERVAL, 3);
        write_thresholds(125, 125, 125);
        run_phase(200, 85, 60, 70);
        wait_drained();

        // contradictory band: min above optimal and max
        write_reg(CFG_INTERVAL, 4);
        write_thresholds(125, -40, -40);
        run_phase(150, 85, 40, 80);
        wait_drained();

        // noise: any interval, unordered thresholds, frequent mode changes
        write_reg(CFG_INTERVAL, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 65534)
                                                             : $urandom_range(2, 9));
        write_thresholds($urandom_range(0, 165) - 40, $urandom_range(0, 165) - 40,
                         $urandom_range(0, 165) - 40);
        run_phase(220, 40, $urandom_range(0, 165) - 40, 80);
        wait_drained();

        // interval that skips ticks between samples
        write_reg(CFG_INTERVAL, 5 + 2 * $urandom_range(0, 4));
        write_ordered_thresholds(topt);
        run_phase(250, 90, topt, 12);
        wait_drained();

        // last stretch at full rate, no idling on either side
        quiet = 1'b1;
        write_reg(CFG_INTERVAL, 2);
        write_thresholds(15, 19, 23);
        run_phase(230, 85, 19, 8);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("covered %0d input words, %0d result words, %0d samples, %0d cooling results",
                 words_sent, results_seen, samples_seen, cooling_seen);
        $display("used %0d register writes across nine settings, extremes included", reg_writes);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS hysteresis_thermostat_moving_average");
        else
            $display("FAIL hysteresis_thermostat_moving_average");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d result words outstanding", expected_results.size());
        $display("FAIL hysteresis_thermostat_moving_average");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hts_pkg.sv
hw/rtl/hts_conv.sv
hw/rtl/hts_core.sv
hw/rtl/hysteresis_thermostat_moving_average.sv
tb/hysteresis_thermostat_moving_average_tb.sv
